[sv/assert_macros.svh]
// Assertion macros for the RTL; ordered_array_list_unit includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[sv/oal_pkg.sv]
`timescale 1ns / 1ps

package oal_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int CNT_W = 7;
	localparam int DATA_W = 32;

	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;
	localparam logic [1:0] OP_DUMP   = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	localparam logic [1:0] SH_HOLD = 2'd0;
	localparam logic [1:0] SH_INS  = 2'd1;
	localparam logic [1:0] SH_DEL  = 2'd2;
	localparam logic [1:0] SH_ROT  = 2'd3;

	typedef struct packed {
		logic [1:0]              operation;
		logic signed [DATA_W-1:0] value;
		logic [CNT_W-1:0]        position;
	} item_t;

	typedef struct packed {
		logic [1:0]              status;
		logic [CNT_W-1:0]        count;
		logic signed [DATA_W-1:0] element;
		logic                    last;
	} result_t;

	typedef struct packed {
		logic [1:0]              code;
		logic [CNT_W-1:0]        pos;
		logic [CNT_W-1:0]        tail;
		logic signed [DATA_W-1:0] data;
	} cell_cmd_t;

endpackage

[sv/oal_cell.sv]
`timescale 1ns / 1ps

module oal_cell #(
	parameter int INDEX = 0
) (
	input  logic                               clk,
	input  oal_pkg::cell_cmd_t                 cmd,
	input  logic signed [oal_pkg::DATA_W-1:0]  lower,
	input  logic signed [oal_pkg::DATA_W-1:0]  upper,
	output logic signed [oal_pkg::DATA_W-1:0]  entry
);
	import oal_pkg::*;

	localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

	logic signed [DATA_W-1:0] entry_q;

	always_ff @(posedge clk) begin
		case (cmd.code)
			SH_INS: begin
				if (IDX > cmd.pos) begin
					entry_q <= lower;
				end else if (IDX == cmd.pos) begin
					entry_q <= cmd.data;
				end
			end
			SH_DEL: begin
				if (IDX >= cmd.pos) begin
					entry_q <= upper;
				end
			end
			SH_ROT: begin
				if (IDX == cmd.tail) begin
					entry_q <= cmd.data;
				end else begin
					entry_q <= upper;
				end
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

	assign entry = entry_q;

endmodule

[sv/ordered_array_list_unit.sv]
`timescale 1ns / 1ps
// Ordered list of up to CAPACITY signed 32-bit entries held in a row of cells.
// Items arrive on item/item_valid/item_stall and each asks to append, insert,
// delete or dump. Results leave on result/result_valid/result_stall.
// A transfer happens on a clock edge where valid is high and stall is low.
// Append, insert and delete give one result, registered in the cycle after the
// transfer; the whole row of cells shifts in that same cycle, so one such
// item can be taken in every cycle while results are drained.
// A dump gives one result per stored entry, one per cycle unless the receiver
// stalls. The transfer enters the dump state; each dump step emits ent[0] and
// rotates the row by one place; the row is back in order when last is loaded.
// A dump of an empty list gives a single result with the empty status.
// No item is taken while a dump is in progress.
// When the receiver stalls, the result register holds its contents and no
// further item or dump step proceeds until it is taken.
// Reset empties the list and clears result_valid; entry contents are
// left as they are and are never read before being written.
module ordered_array_list_unit #(
	parameter int CAPACITY = oal_pkg::CAPACITY_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  oal_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output oal_pkg::result_t result
);
	import oal_pkg::*;

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	logic signed [DATA_W-1:0] ent [CAPACITY];

	logic             dump_q;
	logic [CNT_W-1:0] dump_idx_q;
	logic [CNT_W-1:0] count_q;
	logic             out_valid_q;
	result_t          out_q;

	logic             out_free;
	logic             accept;
	logic             dump_step;
	logic             dump_last;
	cell_cmd_t        cmd;
	logic [1:0]       status;
	logic [CNT_W-1:0] count_nxt;

	assign out_free  = !out_valid_q || !result_stall;
	assign item_stall = dump_q || !out_free;
	assign accept    = item_valid && !item_stall;
	assign dump_step = dump_q && out_free;
	assign dump_last = (dump_idx_q == (count_q - CNT_W'(1)));

	always_comb begin
		cmd.code  = SH_HOLD;
		cmd.pos   = item.position;
		cmd.tail  = count_q - CNT_W'(1);
		cmd.data  = item.value;
		status    = ST_OK;
		count_nxt = count_q;
		if (dump_step) begin
			cmd.code = SH_ROT;
			cmd.data = ent[0];
		end else if (accept) begin
			unique case (item.operation)
				OP_APPEND: begin
					if (count_q >= CAP_CNT) begin
						status = ST_FULL;
					end else begin
						cmd.code  = SH_INS;
						cmd.pos   = count_q;
						count_nxt = count_q + CNT_W'(1);
					end
				end
				OP_INSERT: begin
					if (count_q >= CAP_CNT) begin
						status = ST_FULL;
					end else if (item.position > count_q) begin
						status = ST_RANGE;
					end else begin
						cmd.code  = SH_INS;
						count_nxt = count_q + CNT_W'(1);
					end
				end
				OP_DELETE: begin
					if (count_q == '0) begin
						status = ST_EMPTY;
					end else if (item.position >= count_q) begin
						status = ST_RANGE;
					end else begin
						cmd.code  = SH_DEL;
						count_nxt = count_q - CNT_W'(1);
					end
				end
				default: begin
					if (count_q == '0) begin
						status = ST_EMPTY;
					end
				end
			endcase
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [DATA_W-1:0] lower;
		logic signed [DATA_W-1:0] upper;
		if (i == 0) begin : g_first
			assign lower = '0;
		end else begin : g_mid_lo
			assign lower = ent[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign upper = '0;
		end else begin : g_mid_hi
			assign upper = ent[i+1];
		end
		oal_cell #(
			.INDEX(i)
		) u_cell (
			.clk  (clk),
			.cmd  (cmd),
			.lower(lower),
			.upper(upper),
			.entry(ent[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dump_q      <= 1'b0;
			dump_idx_q  <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (dump_step) begin
				out_valid_q <= 1'b1;
				dump_idx_q  <= dump_idx_q + CNT_W'(1);
				if (dump_last) begin
					dump_q <= 1'b0;
				end
			end else if (accept) begin
				if (item.operation == OP_DUMP && count_q != '0) begin
					dump_q      <= 1'b1;
					dump_idx_q  <= '0;
					out_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dump_step) begin
			out_q.status  <= ST_OK;
			out_q.count   <= count_q;
			out_q.element <= ent[0];
			out_q.last    <= dump_last;
		end else if (accept) begin
			out_q.status  <= status;
			out_q.count   <= count_nxt;
			out_q.element <= '0;
			out_q.last    <= 1'b1;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

`include "assert_macros.svh"

	`ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, count_q <= CAP_CNT)
	`ASSERT_NEXT(a_dump_count_stable, clk, arst_n, dump_q, count_q == $past(count_q))
	`ASSERT_SAME(a_partial_only_dump, clk, arst_n, out_valid_q && !out_q.last, dump_q)

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import oal_pkg::*;

	localparam int CAP = CAPACITY_DEF;

	class list_scoreboard;
		logic signed [DATA_W-1:0] entries [CAP];
		int unsigned n_held;
		result_t due_results[$];
		int errors;

		function void add_result(logic [1:0] status, logic signed [DATA_W-1:0] element,
				logic last);
			result_t r;
			r.status = status;
			r.count = CNT_W'(n_held);
			r.element = element;
			r.last = last;
			due_results.push_back(r);
		endfunction

		function void note_item(item_t it);
			int unsigned k;
			case (it.operation)
				OP_APPEND: begin
					if (n_held >= CAP) begin
						add_result(ST_FULL, '0, 1'b1);
					end else begin
						entries[n_held] = it.value;
						n_held++;
						add_result(ST_OK, '0, 1'b1);
					end
				end
				OP_INSERT: begin
					if (n_held >= CAP) begin
						add_result(ST_FULL, '0, 1'b1);
					end else if (it.position > n_held) begin
						add_result(ST_RANGE, '0, 1'b1);
					end else begin
						for (k = n_held; k > it.position; k--)
							entries[k] = entries[k - 1];
						entries[it.position] = it.value;
						n_held++;
						add_result(ST_OK, '0, 1'b1);
					end
				end
				OP_DELETE: begin
					if (n_held == 0) begin
						add_result(ST_EMPTY, '0, 1'b1);
					end else if (it.position >= n_held) begin
						add_result(ST_RANGE, '0, 1'b1);
					end else begin
						for (k = it.position; k + 1 < n_held; k++)
							entries[k] = entries[k + 1];
						n_held--;
						add_result(ST_OK, '0, 1'b1);
					end
				end
				default: begin
					if (n_held == 0) begin
						add_result(ST_EMPTY, '0, 1'b1);
					end else begin
						for (k = 0; k < n_held; k++)
							add_result(ST_OK, entries[k], k + 1 == n_held);
					end
				end
			endcase
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (due_results.size() == 0) begin
				$error("unexpected result: status %0d count %0d element %0d last %0d",
					got.status, got.count, got.element, got.last);
				errors++;
				return;
			end
			want = due_results.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				errors++;
			end
			if (got.count !== want.count) begin
				$error("count: expected %0d, actual %0d", want.count, got.count);
				errors++;
			end
			if (got.element !== want.element) begin
				$error("element: expected %0d, actual %0d", want.element, got.element);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, actual %0d", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;
	bit steady = 1'b0;

	list_scoreboard sb = new();

	ordered_array_list_unit #(.CAPACITY(CAP)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		result_stall <= !steady && ($urandom_range(0, 99) < 28);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				sb.note_item(item);
			if (result_valid && !result_stall)
				sb.check_result(result);
		end
	end

	function automatic item_t mk(logic [1:0] op, logic [DATA_W-1:0] val, int unsigned pos);
		item_t it;
		it.operation = op;
		it.value = val;
		it.position = CNT_W'(pos);
		return it;
	endfunction

	function automatic int unsigned pick_pos(int unsigned n);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(0, n);
		if (r < 75)
			return n;
		if (r < 85)
			return (n == 0) ? 0 : n - 1;
		return $urandom_range(0, 127);
	endfunction

	function automatic logic [1:0] pick_op(int unsigned w_app, int unsigned w_ins,
			int unsigned w_del);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < w_app)
			return OP_APPEND;
		if (r < w_app + w_ins)
			return OP_INSERT;
		if (r < w_app + w_ins + w_del)
			return OP_DELETE;
		return OP_DUMP;
	endfunction

	task automatic send_item(item_t it);
		while (!steady && $urandom_range(0, 99) < 28) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do
			@(posedge clk);
		while (!(item_valid && !item_stall));
	endtask

	initial begin
		item_t plan[$];
		int guard;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		plan.push_back(mk(OP_DUMP, 32'h0, 0));
		plan.push_back(mk(OP_DELETE, 32'h0, 0));
		plan.push_back(mk(OP_DELETE, 32'h0, 127));
		plan.push_back(mk(OP_INSERT, 32'h1, 1));
		plan.push_back(mk(OP_INSERT, 32'h7fffffff, 0));
		plan.push_back(mk(OP_APPEND, 32'h80000000, 64));
		plan.push_back(mk(OP_APPEND, 32'h0, 0));
		plan.push_back(mk(OP_APPEND, 32'hffffffff, 127));
		plan.push_back(mk(OP_INSERT, 32'h55555555, 2));
		plan.push_back(mk(OP_INSERT, 32'haaaaaaaa, 5));
		plan.push_back(mk(OP_INSERT, 32'h2, 7));
		plan.push_back(mk(OP_INSERT, 32'h3, 127));
		plan.push_back(mk(OP_DUMP, 32'hffffffff, 127));
		plan.push_back(mk(OP_DELETE, 32'h0, 6));
		plan.push_back(mk(OP_DELETE, 32'h0, 64));
		plan.push_back(mk(OP_DELETE, 32'h0, 0));
		plan.push_back(mk(OP_DELETE, 32'h0, 4));
		plan.push_back(mk(OP_DELETE, 32'h0, 1));
		plan.push_back(mk(OP_DUMP, 32'h0, 0));
		plan.push_back(mk(OP_APPEND, 32'h12345678, 0));
		foreach (plan[i])
			send_item(plan[i]);

		// Grow the list until it is full.
		guard = 0;
		while (sb.n_held < CAP && guard < 400) begin
			send_item(mk(pick_op(85, 15, 0), $urandom, pick_pos(sb.n_held)));
			guard++;
		end

		// Requests against a full list, a dump, then drain part of it, without any idling.
		steady = 1'b1;
		repeat (6)
			send_item(mk(pick_op(50, 50, 0), $urandom, $urandom_range(0, 127)));
		send_item(mk(OP_DUMP, $urandom, $urandom_range(0, 127)));
		guard = 0;
		while (sb.n_held > 56 && guard < 60) begin
			send_item(mk(pick_op(10, 5, 80), $urandom, pick_pos(sb.n_held)));
			guard++;
		end
		steady = 1'b0;
		repeat (3)
			send_item(mk(OP_DELETE, $urandom, $urandom_range(0, 127)));
		send_item(mk(OP_DUMP, $urandom, $urandom_range(0, 127)));

		repeat (8)
			send_item(mk(pick_op(30, 30, 30), $urandom, pick_pos(sb.n_held)));

		item_valid <= 1'b0;
		while (sb.due_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.due_results.size() == 0) begin
			$display("PASS ordered_array_list_unit");
		end else begin
			$display("FAIL ordered_array_list_unit");
		end
		$finish;
	end

	initial begin
		#3ms;
		$display("FAIL ordered_array_list_unit");
		$finish;
	end

endmodule
